@@ rtl/ctfd_pkg.sv @@
package ctfd_pkg;

   typedef enum logic [1:0] {
      KIND_SIGNAL = 2'd0,
      KIND_SDO    = 2'd1,
      KIND_CELL   = 2'd2
   } kind_type;

   // signal codes carried in target for named signals
   localparam logic [7:0] SIG_SPEED     = 8'd0;
   localparam logic [7:0] SIG_UDC       = 8'd1;
   localparam logic [7:0] SIG_TMPHS     = 8'd2;
   localparam logic [7:0] SIG_TMPM      = 8'd3;
   localparam logic [7:0] SIG_SOC       = 8'd5;
   localparam logic [7:0] SIG_VMAX      = 8'd6;
   localparam logic [7:0] SIG_VMIN      = 8'd7;
   localparam logic [7:0] SIG_GEAR      = 8'd8;
   localparam logic [7:0] SIG_MOTACTIVE = 8'd9;
   localparam logic [7:0] SIG_REGEN     = 8'd10;

   // identifiers
   localparam logic [10:0] ID_SDO_RSP  = 11'h580;
   localparam logic [10:0] ID_PDO1     = 11'h180;
   localparam logic [10:0] ID_PDO2     = 11'h280;
   localparam logic [10:0] ID_PDO3     = 11'h380;
   localparam logic [10:0] ID_GEAR     = 11'h300;
   localparam logic [10:0] ID_MOTACT   = 11'h301;
   localparam logic [10:0] ID_REGEN    = 11'h302;
   localparam logic [10:0] ID_SHUNT    = 11'h522;
   localparam logic [10:0] ID_SOC      = 11'h355;
   localparam logic [10:0] ID_BMS_TEMP = 11'h356;
   localparam logic [10:0] ID_BMS_VOLT = 11'h373;
   localparam logic [10:0] ID_INV_TEMP = 11'h126;
   localparam logic [10:0] ID_SPEED    = 11'h257;

   localparam logic [15:0] SDO_INDEX      = 16'h2100;
   localparam logic [7:0]  SDO_CMD_UPLD4  = 8'h43;
   localparam logic [7:0]  SDO_CMD_UPLD2  = 8'h4B;
   localparam logic [15:0] TMPM_LIMIT     = 16'd150;

   // reciprocal multipliers: ceil(2^34 / 1000) and ceil(2^26 / 100)
   localparam logic [24:0] RECIP_1000 = 25'd17179870;
   localparam int          SHIFT_1000 = 34;
   localparam logic [19:0] RECIP_100  = 20'd671089;
   localparam int          SHIFT_100  = 26;

   localparam int NODE_RESET = 1;

   typedef struct packed {
      logic [10:0] frame_id;
      logic [3:0]  frame_length;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [7:0]  byte5;
      logic [7:0]  byte6;
      logic [7:0]  byte7;
   } req_word_type;

   typedef struct packed {
      kind_type           update_kind;
      logic [7:0]         target;
      logic signed [31:0] update_value;
      logic [8:0]         cells_seen;
      logic               last_update;
   } rsp_word_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         target;
      logic signed [31:0] value;
   } update_type;

   // all updates of one frame
   typedef struct packed {
      update_type [3:0] slots;
      logic [2:0]       count;
      logic [8:0]       cells_seen;
   } batch_type;

endpackage

@@ rtl/ctfd_decode.sv @@
module ctfd_decode #(
   parameter int MAX_CELLS = 96
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctfd_pkg::req_word_type frame,
   input  logic [6:0]            node_id,
   input  logic                  fire,
   output ctfd_pkg::batch_type   batch
);
   import ctfd_pkg::*;

   logic [8:0]        cell_count_ff;
   logic [8:0]        cell_count_in;
   logic [3:0][15:0]  wu;
   logic [10:0]       id;
   logic [3:0]        len;
   logic              is_cell;
   logic [2:0]        n_words;
   logic [2:0]        kept;
   logic [8:0]        top;
   logic [7:0]        idx;
   logic signed [31:0] sdo_raw;
   logic signed [31:0] sdo_val;
   logic              sdo_ok;
   logic signed [23:0] shunt_raw;
   logic [23:0]       shunt_mag;
   logic [48:0]       shunt_prod;
   logic [14:0]       shunt_q;
   logic signed [31:0] shunt_val;
   logic [15:0]       spd_mag;
   logic [19:0]       spd_mag9;
   logic [39:0]       spd_prod;
   logic [13:0]       spd_q;
   logic signed [31:0] spd_val;
   logic signed [31:0] ws0;
   logic signed [31:0] ws2;
   logic signed [31:0] ws4;
   logic signed [31:0] ws6;

   assign id  = frame.frame_id;
   assign len = frame.frame_length;
   assign wu[0] = {frame.byte1, frame.byte0};
   assign wu[1] = {frame.byte3, frame.byte2};
   assign wu[2] = {frame.byte5, frame.byte4};
   assign wu[3] = {frame.byte7, frame.byte6};
   assign ws0 = 32'(signed'(wu[0]));
   assign ws2 = 32'(signed'(wu[1]));
   assign ws4 = 32'(signed'(wu[2]));
   assign ws6 = 32'(signed'(wu[3]));

   assign is_cell = (id[10:8] == 3'd4) || (id[10:8] == 3'd6);
   assign n_words = (len >= 4'd8) ? 3'd4 : len[3:1];

   // cell indexes rise within a frame, so the kept cells form a prefix
   always_comb begin
      kept = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if ((3'(i) < n_words) && ({1'b0, id[5:0], 2'(i)} < 9'(MAX_CELLS))) begin
            kept = kept + 3'd1;
         end
      end
   end
   assign top = {1'b0, id[5:0], 2'b00} + {6'd0, kept};
   assign cell_count_in = (is_cell && kept != 3'd0 && top > cell_count_ff) ? top
                          : cell_count_ff;

   // SDO value / 32, truncated toward zero
   assign sdo_raw = signed'({frame.byte7, frame.byte6, frame.byte5, frame.byte4});
   assign sdo_val = (sdo_raw + (sdo_raw[31] ? 32'sd31 : 32'sd0)) >>> 5;
   assign sdo_ok  = (len >= 4'd8) && ({frame.byte2, frame.byte1} == SDO_INDEX)
                    && (frame.byte0 == SDO_CMD_UPLD4 || frame.byte0 == SDO_CMD_UPLD2);

   // 24-bit value / 1000 by reciprocal on the magnitude
   assign shunt_raw  = signed'({frame.byte4, frame.byte3, frame.byte2});
   assign shunt_mag  = shunt_raw[23] ? 24'(-shunt_raw) : 24'(shunt_raw);
   assign shunt_prod = 49'(shunt_mag) * 49'(RECIP_1000);
   assign shunt_q    = shunt_prod[48:SHIFT_1000];
   assign shunt_val  = shunt_raw[23] ? -32'(shunt_q) : 32'(shunt_q);

   // speed = raw * 9 / 100, truncated toward zero
   assign spd_mag  = wu[0][15] ? 16'(-wu[0]) : wu[0];
   assign spd_mag9 = {spd_mag, 3'd0} + 20'(spd_mag);
   assign spd_prod = 40'(spd_mag9) * 40'(RECIP_100);
   assign spd_q    = spd_prod[39:SHIFT_100];
   assign spd_val  = wu[0][15] ? -32'(spd_q) : 32'(spd_q);

   always_comb begin
      batch = '0;
      idx   = 8'd0;
      batch.cells_seen = cell_count_in;
      for (int i = 0; i < 4; i++) begin
         batch.slots[i].kind = KIND_SIGNAL;
      end
      if (is_cell) begin
         for (int i = 0; i < 4; i++) begin
            idx = {id[5:0], 2'(i)};
            batch.slots[i].kind   = KIND_CELL;
            batch.slots[i].target = idx;
            batch.slots[i].value  = 32'(wu[i]);
         end
         batch.count = kept;
      end else if (id == ID_SDO_RSP + 11'(node_id)) begin
         batch.slots[0].kind   = KIND_SDO;
         batch.slots[0].target = frame.byte3;
         batch.slots[0].value  = sdo_val;
         batch.count = sdo_ok ? 3'd1 : 3'd0;
      end else if (id == ID_PDO1 + 11'(node_id)) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_SPEED, ws0};
         batch.slots[1] = '{KIND_SIGNAL, SIG_UDC, ws2};
         batch.slots[2] = '{KIND_SIGNAL, SIG_TMPHS, ws4};
         batch.slots[3] = '{KIND_SIGNAL, SIG_TMPM, ws6};
         batch.count = (len >= 4'd8) ? 3'd4 : 3'd0;
      end else if (id == ID_PDO2 + 11'(node_id)) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_TMPHS, ws0};
         batch.slots[1] = '{KIND_SIGNAL, SIG_TMPM, ws2};
         batch.count = (len >= 4'd8) ? 3'd2 : 3'd0;
      end else if (id == ID_PDO3 + 11'(node_id)) begin
         batch.count = 3'd0;
      end else if (id == ID_GEAR) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_GEAR, 32'(frame.byte0)};
         batch.count = (len >= 4'd1) ? 3'd1 : 3'd0;
      end else if (id == ID_MOTACT) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_MOTACTIVE, 32'(frame.byte0)};
         batch.count = (len >= 4'd1) ? 3'd1 : 3'd0;
      end else if (id == ID_REGEN) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_REGEN, ws0};
         batch.count = (len >= 4'd2) ? 3'd1 : 3'd0;
      end else if (id == ID_SHUNT) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_UDC, shunt_val};
         batch.count = (len == 4'd6) ? 3'd1 : 3'd0;
      end else if (id == ID_SOC) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_SOC, ws0};
         batch.count = (len >= 4'd2) ? 3'd1 : 3'd0;
      end else if (id == ID_BMS_TEMP) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_TMPM, ws4};
         batch.count = (len >= 4'd6 && !wu[2][15] && wu[2] <= TMPM_LIMIT) ? 3'd1 : 3'd0;
      end else if (id == ID_BMS_VOLT) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_VMAX, 32'(wu[1])};
         batch.slots[1] = '{KIND_SIGNAL, SIG_VMIN, 32'(wu[0])};
         batch.count = (len >= 4'd6) ? 3'd2 : 3'd0;
      end else if (id == ID_INV_TEMP) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_TMPHS, ws4};
         batch.count = (len >= 4'd6) ? 3'd1 : 3'd0;
      end else if (id == ID_SPEED) begin
         batch.slots[0] = '{KIND_SIGNAL, SIG_SPEED, spd_val};
         batch.count = (len >= 4'd2) ? 3'd1 : 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= '0;
      end else if (fire) begin
         cell_count_ff <= cell_count_in;
      end
   end

endmodule

@@ rtl/ctfd_emit.sv @@
module ctfd_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  ctfd_pkg::batch_type   batch,
   input  logic                  batch_valid,
   output logic                  batch_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ctfd_pkg::rsp_word_type rsp_word
);
   import ctfd_pkg::*;

   update_type [3:0] slots_ff;
   logic [8:0]       seen_ff;
   logic [2:0]       left_ff;
   logic [2:0]       left_in;
   logic [1:0]       ptr_ff;
   logic [1:0]       ptr_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_word_type     rsp_word_ff;
   logic             has;
   logic             out_free;
   logic             move;
   logic             load;

   assign has         = (left_ff != 3'd0);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign move        = has && out_free;
   assign batch_ready = !has || (move && left_ff == 3'd1);
   assign load        = batch_valid && batch_ready;

   always_comb begin
      left_in = left_ff;
      ptr_in  = ptr_ff;
      if (load) begin
         left_in = batch.count;
         ptr_in  = 2'd0;
      end else if (move) begin
         left_in = left_ff - 3'd1;
         ptr_in  = ptr_ff + 2'd1;
      end
      rsp_valid_in = move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the frame's updates while they drain one word per cycle unless rsp_ready stalls
   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= batch.slots;
         seen_ff  <= batch.cells_seen;
      end
      if (move) begin
         rsp_word_ff.update_kind  <= slots_ff[ptr_ff].kind;
         rsp_word_ff.target       <= slots_ff[ptr_ff].target;
         rsp_word_ff.update_value <= slots_ff[ptr_ff].value;
         rsp_word_ff.cells_seen   <= seen_ff;
         rsp_word_ff.last_update  <= (left_ff == 3'd1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/can_telemetry_frame_decoder.sv @@
// channel | direction | word
// --------+-----------+--------------------------------------------
// req_    | in        | req_word_type: identifier, length, 8 bytes
// rsp_    | out       | rsp_word_type: one telemetry update
// csr_    | in        | node_id (7 bits), write only
//
// A frame waits in the input register, is decoded combinationally into the
// update buffer, and its 0 to 4 updates leave the result register one per
// cycle unless rsp_ready stalls; the buffer takes the next frame as the last
// update moves out. Reset (synchronous) empties all stages, clears the cell
// count and sets node_id to 1. A stalled rsp_ready holds the buffer; the
// input register still takes one more frame.
module can_telemetry_frame_decoder #(
   parameter int MAX_CELLS = 96
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ctfd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ctfd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [6:0]             csr_data
);
   import ctfd_pkg::*;

   req_word_type frame_ff;
   logic         frame_valid_ff;
   logic         frame_valid_in;
   logic [6:0]   node_id_ff;
   logic         batch_ready;
   logic         fire;
   logic         req_fire;
   batch_type    batch;

   assign fire      = frame_valid_ff && batch_ready;
   assign req_ready = !frame_valid_ff || batch_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign frame_valid_in = req_fire ? 1'b1 : (fire ? 1'b0 : frame_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         node_id_ff     <= 7'(NODE_RESET);
      end else begin
         frame_valid_ff <= frame_valid_in;
         if (csr_valid) begin
            node_id_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_ff <= req_word;
      end
   end

   ctfd_decode #(
      .MAX_CELLS(MAX_CELLS)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .frame   (frame_ff),
      .node_id (node_id_ff),
      .fire    (fire),
      .batch   (batch)
   );

   ctfd_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .batch       (batch),
      .batch_valid (frame_valid_ff),
      .batch_ready (batch_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import ctfd_pkg::*;

   localparam int CELL_LIMIT   = 96;
   localparam int SETTLE_TICKS = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_FRAMES = 19;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_data = 7'd0;

   // decoder state mirrored on the bench side
   logic [6:0]   node_model = 7'(NODE_RESET);
   logic [8:0]   cell_count = 9'd0;

   rsp_word_type frame_updates[$];
   rsp_word_type pending_updates[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int frames_sent     = 0;
   int updates_checked = 0;
   int node_writes     = 0;
   int error_count     = 0;
   int cycle_count     = 0;

   can_telemetry_frame_decoder #(
      .MAX_CELLS(CELL_LIMIT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d updates outstanding", $time,
                  pending_updates.size());
         $display("can_telemetry_frame_decoder regression: fail");
         $finish;
      end
   end

   function automatic logic signed [31:0] u16(logic [7:0] lo, logic [7:0] hi);
      return {16'd0, hi, lo};
   endfunction

   function automatic logic signed [31:0] s16(logic [7:0] lo, logic [7:0] hi);
      return {{16{hi[7]}}, hi, lo};
   endfunction

   function automatic void push_update(kind_type kind, logic [7:0] tgt,
                                       logic signed [31:0] value);
      rsp_word_type upd;
      upd = '0;
      upd.update_kind  = kind;
      upd.target       = tgt;
      upd.update_value = value;
      frame_updates.push_back(upd);
   endfunction

   // data holds byte0 in its top eight bits down to byte7 in its lowest
   function automatic void decode_frame(logic [10:0] id, logic [3:0] len,
                                        logic [63:0] data);
      logic [7:0] d [8];
      logic [7:0] base;
      logic [7:0] idx;
      int         count;
      int         raw;
      for (int i = 0; i < 8; i++) d[i] = data[63 - 8 * i -: 8];
      frame_updates = {};
      if (id[10:8] == 3'b100 || id[10:8] == 3'b110) begin
         base = {id[5:0], 2'b00};
         count = (len / 2 > 4) ? 4 : len / 2;
         for (int i = 0; i < count; i++) begin
            idx = base + 8'(i);
            if (idx < CELL_LIMIT) begin
               if ({1'b0, idx} >= cell_count) cell_count = {1'b0, idx} + 9'd1;
               push_update(KIND_CELL, idx, u16(d[2 * i], d[2 * i + 1]));
            end
         end
      end else if (id == 11'(ID_SDO_RSP + node_model)) begin
         if (len >= 8 && {d[2], d[1]} == SDO_INDEX &&
             (d[0] == SDO_CMD_UPLD4 || d[0] == SDO_CMD_UPLD2)) begin
            raw = {d[7], d[6], d[5], d[4]};
            push_update(KIND_SDO, d[3], raw / 32);
         end
      end else if (id == 11'(ID_PDO1 + node_model)) begin
         if (len >= 8) begin
            push_update(KIND_SIGNAL, SIG_SPEED, s16(d[0], d[1]));
            push_update(KIND_SIGNAL, SIG_UDC, s16(d[2], d[3]));
            push_update(KIND_SIGNAL, SIG_TMPHS, s16(d[4], d[5]));
            push_update(KIND_SIGNAL, SIG_TMPM, s16(d[6], d[7]));
         end
      end else if (id == 11'(ID_PDO2 + node_model)) begin
         if (len >= 8) begin
            push_update(KIND_SIGNAL, SIG_TMPHS, s16(d[0], d[1]));
            push_update(KIND_SIGNAL, SIG_TMPM, s16(d[2], d[3]));
         end
      end else if (id == 11'(ID_PDO3 + node_model)) begin
         // carries nothing we decode
      end else if (id == ID_GEAR) begin
         if (len >= 1) push_update(KIND_SIGNAL, SIG_GEAR, u16(d[0], 8'd0));
      end else if (id == ID_MOTACT) begin
         if (len >= 1) push_update(KIND_SIGNAL, SIG_MOTACTIVE, u16(d[0], 8'd0));
      end else if (id == ID_REGEN) begin
         if (len >= 2) push_update(KIND_SIGNAL, SIG_REGEN, s16(d[0], d[1]));
      end else if (id == ID_SHUNT) begin
         if (len == 6) begin
            raw = {{8{d[4][7]}}, d[4], d[3], d[2]};
            push_update(KIND_SIGNAL, SIG_UDC, raw / 1000);
         end
      end else if (id == ID_SOC) begin
         if (len >= 2) push_update(KIND_SIGNAL, SIG_SOC, s16(d[0], d[1]));
      end else if (id == ID_BMS_TEMP) begin
         if (len >= 6) begin
            raw = s16(d[4], d[5]);
            if (raw >= 0 && raw <= int'(TMPM_LIMIT)) push_update(KIND_SIGNAL, SIG_TMPM, raw);
         end
      end else if (id == ID_BMS_VOLT) begin
         if (len >= 6) begin
            push_update(KIND_SIGNAL, SIG_VMAX, u16(d[2], d[3]));
            push_update(KIND_SIGNAL, SIG_VMIN, u16(d[0], d[1]));
         end
      end else if (id == ID_INV_TEMP) begin
         if (len >= 6) push_update(KIND_SIGNAL, SIG_TMPHS, s16(d[4], d[5]));
      end else if (id == ID_SPEED) begin
         if (len >= 2) begin
            raw = s16(d[0], d[1]);
            push_update(KIND_SIGNAL, SIG_SPEED, (raw * 9) / 100);
         end
      end
      foreach (frame_updates[i]) begin
         frame_updates[i].cells_seen  = cell_count;
         frame_updates[i].last_update = (i == frame_updates.size() - 1);
         pending_updates.push_back(frame_updates[i]);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_updates
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected update, expected none, actual %h", $time, rsp_word);
            error_count++;
         end else begin
            want = pending_updates.pop_front();
            check_field("update_kind", want.update_kind, rsp_word.update_kind);
            check_field("target", want.target, rsp_word.target);
            check_field("update_value", want.update_value, rsp_word.update_value);
            check_field("cells_seen", want.cells_seen, rsp_word.cells_seen);
            check_field("last_update", want.last_update, rsp_word.last_update);
            updates_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_frame(input logic [10:0] id, input logic [3:0] len,
                             input logic [63:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= {id, len, data};
      do @(posedge clock); while (!req_ready);
      decode_frame(id, len, data);
      frames_sent++;
   endtask

   // hold off the sender until every update is out and the pipe is empty
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic set_node(input logic [6:0] node);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= node;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      node_model = node;
      node_writes++;
   endtask

   task automatic send_random_frame();
      logic [10:0] id;
      logic [3:0]  len;
      logic [63:0] data;
      int          pick;
      pick = $urandom_range(99);
      data = {$urandom, $urandom};
      len  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
      if (pick < 30) begin
         id = {($urandom_range(1) == 0) ? 3'b100 : 3'b110,
               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(23))};
      end else if (pick < 45) begin
         id = ($urandom_range(1) == 0) ? 11'(ID_PDO1 + node_model)
                                       : 11'(ID_PDO2 + node_model);
      end else if (pick < 55) begin
         id = 11'(ID_SDO_RSP + node_model);
         if ($urandom_range(4) != 0) begin
            data[63:56] = ($urandom_range(1) == 0) ? SDO_CMD_UPLD4 : SDO_CMD_UPLD2;
            data[55:40] = {SDO_INDEX[7:0], SDO_INDEX[15:8]};
         end
      end else if (pick < 82) begin
         case ($urandom_range(8))
            0: id = ID_GEAR;
            1: id = ID_MOTACT;
            2: id = ID_REGEN;
            3: begin
               id = ID_SHUNT;
               if ($urandom_range(2) != 0) len = 4'd6;
            end
            4: id = ID_SOC;
            5: begin
               id = ID_BMS_TEMP;
               // keep the temperature near its valid window half of the time
               if ($urandom_range(1) == 0) data[31:16] = {8'($urandom_range(160)), 8'h00};
            end
            6: id = ID_BMS_VOLT;
            7: id = ID_INV_TEMP;
            default: id = ID_SPEED;
         endcase
      end else if (pick < 87) begin
         id = 11'(ID_PDO3 + node_model);
      end else begin
         id  = 11'($urandom);
         len = 4'($urandom);
      end
      send_frame(id, len, data);
   endtask

   task automatic test_broadcast_frames();
      send_frame(ID_GEAR, 4'd1, 64'hFF00_0000_0000_0000);
      send_frame(ID_GEAR, 4'd0, 64'h1200_0000_0000_0000);
      send_frame(ID_MOTACT, 4'd1, 64'h0000_0000_0000_0000);
      send_frame(ID_REGEN, 4'd2, 64'h0080_0000_0000_0000);
      send_frame(ID_SOC, 4'd15, 64'hFF7F_FFFF_FFFF_FFFF);
      send_frame(ID_BMS_TEMP, 4'd6, 64'h0000_0000_9600_0000);
      send_frame(ID_BMS_TEMP, 4'd6, 64'h0000_0000_9700_0000);
      send_frame(ID_BMS_TEMP, 4'd8, 64'h0000_0000_FFFF_0000);
      send_frame(ID_BMS_TEMP, 4'd6, 64'hFFFF_FFFF_0000_FFFF);
      send_frame(ID_BMS_VOLT, 4'd6, 64'h3412_FFFF_0000_0000);
      send_frame(ID_BMS_VOLT, 4'd5, 64'h3412_FFFF_0000_0000);
      send_frame(ID_INV_TEMP, 4'd6, 64'h0000_0000_0080_0000);
      send_frame(ID_SPEED, 4'd2, 64'h0080_0000_0000_0000);
      send_frame(ID_SPEED, 4'd2, 64'hF5FF_0000_0000_0000);
      send_frame(ID_SPEED, 4'd8, 64'hFF7F_0000_0000_0000);
      send_frame(ID_SHUNT, 4'd6, 64'h0000_0000_8000_0000);
      send_frame(ID_SHUNT, 4'd7, 64'h0000_FFFF_7F00_0000);
      send_frame(ID_SHUNT, 4'd6, 64'h0000_FFFF_7F00_0000);
      send_frame(11'h000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      send_frame(11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   // 0x411 would carry idc but decodes as cells, as does PDO4
   task automatic test_cell_frames();
      send_frame(11'h411, 4'd8, 64'h0102_0304_0506_0708);
      send_frame(11'h481, 4'd7, 64'hFFFF_0000_AA55_FFFF);
      send_frame(11'h417, 4'd8, 64'h1122_3344_5566_7788);
      send_frame(11'h418, 4'd8, 64'h1122_3344_5566_7788);
      send_frame(11'h6FF, 4'd8, 64'h1122_3344_5566_7788);
      send_frame(11'h600, 4'd1, 64'h1122_3344_5566_7788);
   endtask

   task automatic test_node_frames();
      send_frame(11'(ID_PDO1 + node_model), 4'd8, 64'h0080_FF7F_FFFF_0100);
      send_frame(11'(ID_PDO1 + node_model), 4'd7, 64'h0080_FF7F_FFFF_0100);
      send_frame(11'(ID_PDO2 + node_model), 4'd8, 64'hFFFF_0080_0000_0000);
      send_frame(11'(ID_PDO3 + node_model), 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      send_frame(11'(ID_SDO_RSP + node_model), 4'd8, 64'h4300_2107_0000_0080);
      send_frame(11'(ID_SDO_RSP + node_model), 4'd8, 64'h4B00_21FF_FFFF_FFFF);
      send_frame(11'(ID_SDO_RSP + node_model), 4'd8, 64'h4000_2107_0000_0080);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [6:0] node);
      set_node(node);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (PHASE_FRAMES) send_random_frame();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_broadcast_frames();
      test_cell_frames();
      test_node_frames();
      test_random_phase(0, 0, 7'd0);
      test_random_phase(52, 0, 7'd127);
      test_random_phase(0, 52, 7'($urandom));
      test_random_phase(20, 20, 7'($urandom));
      wait_drain();
      $display("Ran %0d frames and checked %0d updates across %0d node_id settings,",
               frames_sent, updates_checked, node_writes + 1);
      $display("with cell count reaching %0d under idle and stall mixes.", cell_count);
      if (error_count == 0) begin
         $display("can_telemetry_frame_decoder regression: pass");
      end else begin
         $display("can_telemetry_frame_decoder regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ctfd_pkg.sv
rtl/ctfd_decode.sv
rtl/ctfd_emit.sv
rtl/can_telemetry_frame_decoder.sv
bench/testbench.sv
